FILE: rtl/pkcs7_pkg.sv
// ----------------------------------------------------------------------------
// pkcs7_pkg
// Shared types and constants of the PKCS#7 pad / unpad stream block.
// ----------------------------------------------------------------------------
`default_nettype none

package pkcs7_pkg;

  localparam int BYTE_W = 8;
  localparam int BS_W   = 5;

  localparam logic [BS_W-1:0] BS_RESET = 5'd16;
  localparam logic [BS_W-1:0] BS_MIN   = 5'd2;

  localparam logic MODE_PAD   = 1'b0;
  localparam logic MODE_UNPAD = 1'b1;

  typedef enum logic {
    REG_MODE       = 1'b0,
    REG_BLOCK_SIZE = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_SIZE = 2'd1,
    STAT_BAD_PAD  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_STREAM,
    ST_PAD,
    ST_UNEND,
    ST_CHECK,
    ST_EMIT,
    ST_STATUS
  } state_t;

  typedef enum logic [1:0] {
    OSEL_NONE,
    OSEL_PAD,
    OSEL_HELD,
    OSEL_STATUS
  } osel_t;

  typedef struct packed {
    logic    accept;
    osel_t   out_sel;
    logic    out_last;
    status_t stat_code;
    logic    pad_latch;
    logic    idx_dec;
    logic    idx_clr;
    logic    idx_inc;
    logic    rem_dec;
    logic    clear_stream;
  } cmd_t;

  typedef struct packed {
    logic can_load;
    logic bs_ok;
    logic mode;
    logic len_ok;
    logic pad_ok;
    logic match;
    logic idx_at_lim;
    logic lim_zero;
    logic emit_last;
    logic rem_one;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/pkcs7_ctrl.sv
// ----------------------------------------------------------------------------
// pkcs7_ctrl
// Controller: input acceptance and the end-of-message sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module pkcs7_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_end_of_message,
  output logic                  in_ready,
  output pkcs7_pkg::cmd_t       cmd,
  input  wire pkcs7_pkg::stat_t st
);
  import pkcs7_pkg::*;

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_STREAM;
      code_r  <= STAT_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_STREAM: begin
        in_ready = st.can_load;
        if (in_valid && st.can_load) begin
          cmd.accept = 1'b1;
          if (in_end_of_message) begin
            if (!st.bs_ok) begin
              code_nxt  = STAT_BAD_SIZE;
              state_nxt = ST_STATUS;
            end else if (st.mode == MODE_PAD) begin
              state_nxt = ST_PAD;
            end else begin
              state_nxt = ST_UNEND;
            end
          end
        end
      end
      ST_PAD: begin
        if (st.can_load) begin
          cmd.out_sel  = OSEL_PAD;
          cmd.out_last = st.rem_one;
          cmd.rem_dec  = 1'b1;
          if (st.rem_one) begin
            cmd.clear_stream = 1'b1;
            state_nxt        = ST_STREAM;
          end
        end
      end
      ST_UNEND: begin
        if (st.len_ok) begin
          cmd.pad_latch = 1'b1;
          state_nxt     = ST_CHECK;
        end else begin
          code_nxt  = STAT_BAD_PAD;
          state_nxt = ST_STATUS;
        end
      end
      ST_CHECK: begin
        if (!st.pad_ok || !st.match) begin
          code_nxt  = STAT_BAD_PAD;
          state_nxt = ST_STATUS;
        end else if (st.idx_at_lim) begin
          code_nxt    = STAT_OK;
          cmd.idx_clr = 1'b1;
          state_nxt   = st.lim_zero ? ST_STATUS : ST_EMIT;
        end else begin
          cmd.idx_dec = 1'b1;
        end
      end
      ST_EMIT: begin
        if (st.can_load) begin
          cmd.out_sel = OSEL_HELD;
          cmd.idx_inc = 1'b1;
          if (st.emit_last) begin
            state_nxt = ST_STATUS;
          end
        end
      end
      ST_STATUS: begin
        if (st.can_load) begin
          cmd.out_sel      = OSEL_STATUS;
          cmd.out_last     = 1'b1;
          cmd.stat_code    = code_r;
          cmd.clear_stream = 1'b1;
          state_nxt        = ST_STREAM;
        end
      end
      default: begin
        state_nxt = ST_STREAM;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/pkcs7_dp.sv
// ----------------------------------------------------------------------------
// pkcs7_dp
// Datapath: registers, held byte line, counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pkcs7_dp #(
  parameter int MAX_BLOCK = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_index,
  input  wire logic [pkcs7_pkg::BS_W-1:0]       cfg_wdata,
  input  wire logic [pkcs7_pkg::BYTE_W-1:0]     in_data_byte,
  input  wire logic                             in_carries_byte,
  input  wire logic                             in_end_of_message,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic [pkcs7_pkg::BYTE_W-1:0]          out_byte,
  output logic                                  out_byte_valid,
  output logic                                  out_run_last,
  output logic [1:0]                            out_status,
  input  wire pkcs7_pkg::cmd_t                  cmd,
  output pkcs7_pkg::stat_t                      st
);
  import pkcs7_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int IDX_W = $clog2(MAX_BLOCK);
  localparam int BW    = (CNT_W > BS_W) ? CNT_W : BS_W;

  logic              mode_r;
  logic [BS_W-1:0]   bs_r;
  logic [BYTE_W-1:0] held_r   [MAX_BLOCK];
  logic [BYTE_W-1:0] held_nxt [MAX_BLOCK];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic              seen_r;
  logic [IDX_W-1:0]  idx_r;
  logic [BYTE_W-1:0] pad_r;
  logic [CNT_W-1:0]  rem_r;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_bv_r, out_bv_nxt;
  logic              out_last_r, out_last_nxt;
  status_t           out_stat_r, out_stat_nxt;

  logic              bs_ok, unpad, full, byte_go, shift, wr, clear, end_go, stream_emit;
  logic [CNT_W-1:0]  bs_c, pos_inc, pad_cnt, wa, lim;
  logic [IDX_W-1:0]  pos_after;
  logic [BYTE_W-1:0] held_rd;

  assign bs_ok = (BW'(bs_r) >= BW'(BS_MIN)) && (BW'(bs_r) <= BW'(MAX_BLOCK));
  assign bs_c  = CNT_W'(bs_r);
  assign unpad = (mode_r == MODE_UNPAD);
  assign full  = (cnt_r >= bs_c);

  assign byte_go     = cmd.accept && in_carries_byte && bs_ok;
  assign end_go      = cmd.accept && in_end_of_message;
  assign stream_emit = byte_go && (!unpad || full);
  assign wr          = byte_go && unpad;
  assign shift       = wr && full;
  assign wa          = shift ? (cnt_r - CNT_W'(1)) : cnt_r;
  assign clear       = cmd.clear_stream || cfg_we;

  assign pos_inc   = CNT_W'(pos_r) + CNT_W'(1);
  assign pos_nxt   = (pos_inc >= bs_c) ? '0 : pos_inc[IDX_W-1:0];
  assign pos_after = byte_go ? pos_nxt : pos_r;
  assign pad_cnt   = bs_c - CNT_W'(pos_after);

  assign held_rd = held_r[idx_r];
  assign lim     = bs_c - CNT_W'(pad_r);

  // held line: shift toward entry 0 when the oldest byte leaves
  genvar g;
  for (g = 0; g < MAX_BLOCK; g++) begin : g_held
    logic [BYTE_W-1:0] shifted;
    if (g < MAX_BLOCK - 1) begin : g_mid
      assign shifted = held_r[g+1];
    end else begin : g_top
      assign shifted = held_r[g];
    end
    assign held_nxt[g] = (wr && (wa == CNT_W'(g))) ? in_data_byte :
                         (shift ? shifted : held_r[g]);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_BLOCK; i++) begin
      held_r[i] <= held_nxt[i];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (clear) begin
      cnt_nxt = '0;
    end else if (wr && !full) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PAD;
      bs_r   <= BS_RESET;
      cnt_r  <= '0;
      pos_r  <= '0;
      seen_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_MODE:       mode_r <= cfg_wdata[0];
          REG_BLOCK_SIZE: bs_r   <= cfg_wdata;
        endcase
      end
      cnt_r <= cnt_nxt;
      if (clear) begin
        pos_r  <= '0;
        seen_r <= 1'b0;
      end else if (byte_go) begin
        pos_r  <= pos_nxt;
        seen_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (end_go) begin
      idx_r <= IDX_W'(bs_c - CNT_W'(1));
      pad_r <= BYTE_W'(pad_cnt);
      rem_r <= pad_cnt;
    end else begin
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_dec) begin
        idx_r <= idx_r - IDX_W'(1);
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.pad_latch) begin
        pad_r <= held_rd;
      end
      if (cmd.rem_dec) begin
        rem_r <= rem_r - CNT_W'(1);
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_last_nxt  = out_last_r;
    out_stat_nxt  = out_stat_r;
    if (stream_emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = unpad ? held_r[0] : in_data_byte;
      out_bv_nxt    = 1'b1;
      out_last_nxt  = 1'b0;
      out_stat_nxt  = STAT_OK;
    end
    unique case (cmd.out_sel)
      OSEL_NONE: begin
      end
      OSEL_PAD: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = pad_r;
        out_bv_nxt    = 1'b1;
        out_last_nxt  = cmd.out_last;
        out_stat_nxt  = STAT_OK;
      end
      OSEL_HELD: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = held_rd;
        out_bv_nxt    = 1'b1;
        out_last_nxt  = 1'b0;
        out_stat_nxt  = STAT_OK;
      end
      OSEL_STATUS: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = '0;
        out_bv_nxt    = 1'b0;
        out_last_nxt  = 1'b1;
        out_stat_nxt  = cmd.stat_code;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_bv_r   <= out_bv_nxt;
    out_last_r <= out_last_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_run_last   = out_last_r;
  assign out_status     = out_stat_r;

  assign st.can_load   = !out_valid_r || out_ready;
  assign st.bs_ok      = bs_ok;
  assign st.mode       = mode_r;
  assign st.len_ok     = seen_r && (pos_r == '0) && (cnt_r == bs_c);
  assign st.pad_ok     = (pad_r != '0) && (pad_r <= BYTE_W'(bs_r));
  assign st.match      = (held_rd == pad_r);
  assign st.idx_at_lim = (CNT_W'(idx_r) == lim);
  assign st.lim_zero   = (lim == '0);
  assign st.emit_last  = ((CNT_W'(idx_r) + CNT_W'(1)) == lim);
  assign st.rem_one    = (rem_r == CNT_W'(1));

endmodule

`default_nettype wire

FILE: rtl/pkcs7_pad_unpad_stream.sv
// ----------------------------------------------------------------------------
// pkcs7_pad_unpad_stream
// Adds or checks and strips PKCS#7 padding on a byte stream.
// ----------------------------------------------------------------------------
// Input items (in_*) carry one message byte, an end marker, or both; result
// items (out_*) carry a data or pad byte, or a status-only final item.
// Both channels use valid/ready. The cfg port writes mode and block size
// and clears the held stream state; write it only while the block is idle.
// While streaming, one item is accepted per cycle unless the output stalls; a
// byte enters the output register as it is accepted (pad mode) or once a full
// block is held behind it (unpad mode).
// End of message, pad mode: block_size minus (length mod block_size) pad
// bytes, one per cycle while the output can load. Unpad mode: the length
// check and the pad value read, a check of each pad byte, then each held
// data byte and the status item, all driven by a single read index into the
// held byte line. No input is accepted during this end sequence.
// A stalled receiver holds the output register; input then waits too.
// Reset sets mode to pad, block size to 16 and empties the stream state.
// ----------------------------------------------------------------------------
`default_nettype none

module pkcs7_pad_unpad_stream #(
  parameter int MAX_BLOCK = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [pkcs7_pkg::BS_W-1:0]   cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [pkcs7_pkg::BYTE_W-1:0] in_data_byte,
  input  wire logic                         in_carries_byte,
  input  wire logic                         in_end_of_message,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [pkcs7_pkg::BYTE_W-1:0]      out_byte,
  output logic                              out_byte_valid,
  output logic                              out_run_last,
  output logic [1:0]                        out_status
);
  import pkcs7_pkg::*;

  cmd_t  cmd;
  stat_t st;

  pkcs7_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_end_of_message (in_end_of_message),
    .in_ready          (in_ready),
    .cmd               (cmd),
    .st                (st)
  );

  pkcs7_dp #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_data_byte      (in_data_byte),
    .in_carries_byte   (in_carries_byte),
    .in_end_of_message (in_end_of_message),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_run_last      (out_run_last),
    .out_status        (out_status),
    .cmd               (cmd),
    .st                (st)
  );

endmodule

`default_nettype wire

FILE: rtl/pkcs7_chk.sv
// ----------------------------------------------------------------------------
// pkcs7_chk
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pkcs7_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_byte_valid,
  input wire logic       out_run_last,
  input wire logic [1:0] out_status
);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_byte_valid) && $stable(out_run_last) && $stable(out_status))
    else $error("result item changed while stalled");

  // status-only item ends a message and carries no byte
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_run_last && (out_byte == 8'd0))
    else $error("status-only item not final or byte nonzero");

  // byte items always report ok status
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> (out_status == 2'd0))
    else $error("byte item with nonzero status");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pkcs7_pad_unpad_stream pkcs7_chk u_chk (.*);

`default_nettype wire
